FILE: hdl/hjbp_pkg.sv
// Shared constants, types and codes of the hash join build and probe unit.
// No dependencies; every other file imports this package.
package hjbp_pkg;

	localparam int BUCKET_CNT   = 1024;
	localparam int POOL_ENTRIES = 1024;
	localparam int KEY_BITS     = 32;
	localparam int BKT_W        = $clog2(BUCKET_CNT);
	localparam int IDX_W        = $clog2(POOL_ENTRIES);
	localparam int FILL_W       = IDX_W + 1;
	localparam int MASK_W       = 10;
	localparam int CNT_W        = 32;
	localparam int MODE_W       = 2;

	localparam logic [FILL_W-1:0] POOL_CAP  = FILL_W'(POOL_ENTRIES);
	localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
	localparam logic [BKT_W-1:0]  BKT_LAST  = BKT_W'(BUCKET_CNT - 1);
	localparam logic [MASK_W-1:0] MASK_INIT = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_BUILD = 2'd0,
		MODE_PROBE = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} link_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		link_t               link;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} pool_req_t;

endpackage

FILE: hdl/hjbp_ifs.sv
// Valid/ready channel interfaces: input items, result items, mask writes.
// Depends on hjbp_pkg for field widths.
interface hjbp_in_if import hjbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [31:0]       join_key;
	logic              last_item;
	modport source (output valid, mode, join_key, last_item, input ready);
	modport sink (input valid, mode, join_key, last_item, output ready);
endinterface

interface hjbp_out_if import hjbp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             stored;
	logic             pool_full;
	logic             matched;
	logic [CNT_W-1:0] match_total;
	logic             relation_done;
	modport source (output valid, stored, pool_full, matched, match_total, relation_done,
		input ready);
	modport sink (input valid, stored, pool_full, matched, match_total, relation_done,
		output ready);
endinterface

interface hjbp_cfg_if import hjbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] bucket_mask;
	modport source (output valid, bucket_mask, input ready);
	modport sink (input valid, bucket_mask, output ready);
endinterface

FILE: hdl/hjbp_pool.sv
// Entry pool memory: key and chain link of each pool entry.
// One write and one registered read per cycle; depends on hjbp_pkg.
module hjbp_pool import hjbp_pkg::*; (
	input  logic      clk,
	input  pool_req_t req,
	output entry_t    rdata_q
);

	entry_t mem_q [POOL_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

endmodule

FILE: hdl/hash_join_build_probe_unit.sv
// Channel    Role    Payload
// in_ch      sink    mode, join_key, last_item
// out_ch     source  stored, pool_full, matched, match_total, relation_done
// cfg        sink    bucket_mask (always ready)
//
// Build and unused mode: each item passes S_HEAD, then S_DONE, where the result register is loaded.
// Probe: S_HEAD, then S_WALK once per chain entry visited (one pool memory read each), then S_DONE.
// Clear: the item runs the one-entry-a-cycle sweep of the heads, then S_DONE.
// After reset the head sweep clears every bucket head before the first accept.
// One item at a time; a new item is taken while the previous result waits in out_ch.
// A stalled out_ch holds the next result in S_DONE until the register frees.
// Top level of the hash join engine; depends on hjbp_pkg, hjbp_ifs, hjbp_pool.
module hash_join_build_probe_unit import hjbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hjbp_in_if.sink   in_ch,
	hjbp_out_if.source out_ch,
	hjbp_cfg_if.sink  cfg
);

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [BKT_W-1:0]    sweep_idx_q;
	logic                sweep_item_q;
	logic [MASK_W-1:0]   mask_q;
	logic [MODE_W-1:0]   mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic                last_q;
	logic [BKT_W-1:0]    bkt_q;
	logic [FILL_W-1:0]   fill_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                stored_q;
	logic                full_q;
	logic                matched_q;

	logic             out_valid_q;
	logic             out_stored_q;
	logic             out_full_q;
	logic             out_matched_q;
	logic [CNT_W-1:0] out_total_q;
	logic             out_done_q;

	link_t            head_mem_q [BUCKET_CNT];
	link_t            head_rdata_q;
	logic             head_we;
	logic [BKT_W-1:0] head_waddr;
	link_t            head_wdata;
	logic [BKT_W-1:0] in_bkt;

	pool_req_t pool_req;
	entry_t    pool_rdata;
	logic      accept;
	logic      out_free;
	logic      pool_has_room;

	assign accept        = in_ch.valid && in_ch.ready;
	assign in_ch.ready   = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_valid_q || out_ch.ready;
	assign pool_has_room = (fill_q != POOL_CAP);
	assign in_bkt        = BKT_W'(in_ch.join_key[MASK_W-1:0] & mask_q);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.stored        = out_stored_q;
	assign out_ch.pool_full     = out_full_q;
	assign out_ch.matched       = out_matched_q;
	assign out_ch.match_total   = out_total_q;
	assign out_ch.relation_done = out_done_q;

	always_comb begin
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = '{valid: 1'b1, idx: fill_q[IDX_W-1:0]};
		pool_req   = '{we: 1'b0, waddr: fill_q[IDX_W-1:0],
			wdata: '{key: key_q, link: head_rdata_q}, raddr: head_rdata_q.idx};
		if (state_q == S_SWEEP) begin
			head_we    = 1'b1;
			head_waddr = sweep_idx_q;
			head_wdata = '0;
		end else if (state_q == S_HEAD && mode_q == MODE_BUILD && pool_has_room) begin
			head_we     = 1'b1;
			pool_req.we = 1'b1;
		end
		if (state_q == S_WALK) begin
			pool_req.raddr = pool_rdata.link.idx;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem_q[head_waddr] <= head_wdata;
		end
		head_rdata_q <= head_mem_q[in_bkt];
	end

	hjbp_pool u_pool (
		.clk     (clk),
		.req     (pool_req),
		.rdata_q (pool_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			sweep_idx_q   <= '0;
			sweep_item_q  <= 1'b0;
			mask_q        <= MASK_INIT;
			mode_q        <= '0;
			key_q         <= '0;
			last_q        <= 1'b0;
			bkt_q         <= '0;
			fill_q        <= '0;
			cnt_q         <= '0;
			stored_q      <= 1'b0;
			full_q        <= 1'b0;
			matched_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_stored_q  <= 1'b0;
			out_full_q    <= 1'b0;
			out_matched_q <= 1'b0;
			out_total_q   <= '0;
			out_done_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				mask_q <= cfg.bucket_mask;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + 1'b1;
					if (sweep_idx_q == BKT_LAST) begin
						sweep_item_q <= 1'b0;
						state_q      <= sweep_item_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q    <= in_ch.mode;
						key_q     <= in_ch.join_key[KEY_BITS-1:0];
						last_q    <= in_ch.last_item;
						bkt_q     <= in_bkt;
						stored_q  <= 1'b0;
						full_q    <= 1'b0;
						matched_q <= 1'b0;
						if (in_ch.mode == MODE_CLEAR) begin
							fill_q       <= '0;
							cnt_q        <= '0;
							sweep_item_q <= 1'b1;
							state_q      <= S_SWEEP;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					case (mode_q)
						MODE_BUILD: begin
							if (pool_has_room) begin
								fill_q   <= fill_q + 1'b1;
								stored_q <= 1'b1;
							end else begin
								full_q <= 1'b1;
							end
							state_q <= S_DONE;
						end
						MODE_PROBE: begin
							state_q <= head_rdata_q.valid ? S_WALK : S_DONE;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_WALK: begin
					if (pool_rdata.key == key_q) begin
						matched_q <= 1'b1;
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (!pool_rdata.link.valid) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_stored_q  <= stored_q;
						out_full_q    <= full_q;
						out_matched_q <= matched_q;
						out_total_q   <= cnt_q;
						out_done_q    <= last_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/hjbp_checker.sv
// Port-level checks of the hash join unit, bound to the top level.
// Depends on hjbp_pkg and the top level hash_join_build_probe_unit.
module hjbp_checker import hjbp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             stored,
	input logic             pool_full,
	input logic             matched,
	input logic [CNT_W-1:0] match_total,
	input logic             relation_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(match_total) && $stable(stored)
			&& $stable(matched) && $stable(relation_done))
		else $error("result item changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({stored, pool_full, matched}) <= 1)
		else $error("build and probe flags set together");

	a_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> match_total != '0)
		else $error("match reported with zero running count");

endmodule

bind hash_join_build_probe_unit hjbp_checker u_hjbp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.stored        (out_ch.stored),
	.pool_full     (out_ch.pool_full),
	.matched       (out_ch.matched),
	.match_total   (out_ch.match_total),
	.relation_done (out_ch.relation_done)
);
